// ===== rtl/h2r_pkg.sv =====
package h2r_pkg;

  // Input transfer: one HSV colour.
  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
  } hsv_t;

  // Result transfer: one RGB colour.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Hue sector index, 0 to 8 for hues 0 to 511.
  typedef logic [3:0] sector_t;

  // Sector codes; hues of 300 and more fall into the magenta-to-red case.
  localparam sector_t SectorRedYellow   = 4'd0;
  localparam sector_t SectorYellowGreen = 4'd1;
  localparam sector_t SectorGreenCyan   = 4'd2;
  localparam sector_t SectorCyanBlue    = 4'd3;
  localparam sector_t SectorBlueMagenta = 4'd4;

  // Degrees per sector, and its reciprocal scaled by 2^16 (exact for hues below 512).
  localparam logic [5:0]  DegPerSector = 6'd60;
  localparam logic [10:0] SectorRecip  = 11'd1093;

  // Full scale of the fixed-point products.
  localparam logic [8:0]  Scale        = 9'd256;

endpackage

// ===== rtl/h2r_hue_split.sv =====
module h2r_hue_split
  import h2r_pkg::*;
(
  input  logic       clk_i,
  input  logic [8:0] hue_i,
  output sector_t    sector_o,
  output logic [7:0] frac_o
);

  logic [19:0] recip_prod;
  logic [8:0]  hue_q;
  sector_t     sector_q;
  sector_t     sector2_q;
  sector_t     sector3_q;
  logic [8:0]  sector_deg;
  logic [8:0]  rem_full;
  logic [5:0]  rem_q;
  logic [9:0]  rem_x17;
  logic [7:0]  frac_q;

  // First stage: the sector is hue divided by 60, taken from a reciprocal product.
  assign recip_prod = 20'(hue_i) * 20'(SectorRecip);

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_i;
    sector_q <= recip_prod[19:16];
  end

  // Second stage: the remainder within the sector.
  assign sector_deg = 9'(sector_q) * 9'(DegPerSector);
  assign rem_full   = hue_q - sector_deg;

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_full[5:0];
    sector2_q <= sector_q;
  end

  // Third stage: the fraction rem * 255 / 60 equals rem * 17 / 4 exactly.
  assign rem_x17 = {rem_q, 4'b0000} + 10'(rem_q);

  always_ff @(posedge clk_i) begin
    frac_q    <= rem_x17[9:2];
    sector3_q <= sector2_q;
  end

  assign sector_o = sector3_q;
  assign frac_o   = frac_q;

endmodule

// ===== rtl/hsv_to_rgb_integer.sv =====
// Six-stage pipeline; results leave it in the order their colours came in.
// One colour is taken in every clock cycle; busy is never raised.
// The done strobe is high for one cycle with each result, which the
// receiver must take then, since it cannot stall the pipeline.
// Reset clears the valid bits only; the data registers are not reset.
module hsv_to_rgb_integer
  import h2r_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  hsv_t in_i,
  output logic done_o,
  output rgb_t out_o
);

  logic [5:0] valid_q;
  logic [5:0] valid_d;

  logic [7:0] val1_q, val2_q, val3_q, val4_q, val5_q;
  logic [7:0] sat1_q, sat2_q, sat3_q;
  logic [7:0] p2_q, p3_q, p4_q, p5_q;
  logic [7:0] sf4_q, snf4_q;
  logic [7:0] q5_q, t5_q;
  sector_t    sector4_q, sector5_q;
  rgb_t       out_q;
  rgb_t       out_d;

  sector_t    sector3;
  logic [7:0] frac3;
  logic [16:0] p_prod;
  logic [15:0] sf_prod;
  logic [16:0] snf_prod;
  logic [16:0] q_prod;
  logic [16:0] t_prod;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Valid bits travel alongside the data.
  assign valid_d = {valid_q[4:0], start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Sector and fraction of the hue, three stages deep.
  h2r_hue_split u_hue_split (
    .clk_i    (clk_i),
    .hue_i    (in_i.hue),
    .sector_o (sector3),
    .frac_o   (frac3)
  );

  // Stage one: capture saturation and value.
  always_ff @(posedge clk_i) begin
    val1_q <= in_i.value;
    sat1_q <= in_i.saturation;
  end

  // Stage two: p = value * (256 - saturation) / 256.
  assign p_prod = 17'(val1_q) * 17'(Scale - 9'(sat1_q));

  always_ff @(posedge clk_i) begin
    val2_q <= val1_q;
    sat2_q <= sat1_q;
    p2_q   <= p_prod[15:8];
  end

  // Stage three: wait for the fraction.
  always_ff @(posedge clk_i) begin
    val3_q <= val2_q;
    sat3_q <= sat2_q;
    p3_q   <= p2_q;
  end

  // Stage four: saturation scaled by the fraction and by its complement.
  assign sf_prod  = 16'(sat3_q) * 16'(frac3);
  assign snf_prod = 17'(sat3_q) * 17'(Scale - 9'(frac3));

  always_ff @(posedge clk_i) begin
    val4_q    <= val3_q;
    p4_q      <= p3_q;
    sector4_q <= sector3;
    sf4_q     <= sf_prod[15:8];
    snf4_q    <= snf_prod[15:8];
  end

  // Stage five: q and t.
  assign q_prod = 17'(val4_q) * 17'(Scale - 9'(sf4_q));
  assign t_prod = 17'(val4_q) * 17'(Scale - 9'(snf4_q));

  always_ff @(posedge clk_i) begin
    val5_q    <= val4_q;
    p5_q      <= p4_q;
    sector5_q <= sector4_q;
    q5_q      <= q_prod[15:8];
    t5_q      <= t_prod[15:8];
  end

  // Stage six: order the channels by sector. Zero saturation gives
  // p = q = t = value, so grey needs no case of its own.
  always_comb begin
    unique case (sector5_q)
      SectorRedYellow:   out_d = '{red: val5_q, green: t5_q,   blue: p5_q};
      SectorYellowGreen: out_d = '{red: q5_q,   green: val5_q, blue: p5_q};
      SectorGreenCyan:   out_d = '{red: p5_q,   green: val5_q, blue: t5_q};
      SectorCyanBlue:    out_d = '{red: p5_q,   green: q5_q,   blue: val5_q};
      SectorBlueMagenta: out_d = '{red: t5_q,   green: p5_q,   blue: val5_q};
      default:           out_d = '{red: val5_q, green: p5_q,   blue: q5_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o  = out_q;
  assign done_o = valid_q[5];

endmodule

// ===== tb/hsv_to_rgb_integer_checker.sv =====
// Watches both channels of the colour converter. It predicts each RGB result
// from the HSV transfer and compares results in order of arrival.
module hsv_to_rgb_integer_checker
  import h2r_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  hsv_t hsv_i,
  input  logic done_i,
  input  rgb_t rgb_i,
  output int   error_count_o,
  output int   pending_o,
  output int   checked_o
);

  // Full scale of the fractional hue position within a sector.
  localparam int unsigned FracFull = 255;

  rgb_t expected_colours[$];
  int   fail_count    = 0;
  int   pending_count = 0;
  int   checked_count = 0;

  assign error_count_o = fail_count;
  assign pending_o     = pending_count;
  assign checked_o     = checked_count;

  // Integer HSV to RGB conversion with truncating scale-by-256 arithmetic.
  function automatic rgb_t predict_rgb(hsv_t colour);
    int unsigned sat;
    int unsigned val;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t     sector;
    rgb_t        rgb;
    sat = colour.saturation;
    val = colour.value;
    if (sat == 0) begin
      // A grey colour carries the value on every channel.
      rgb.red   = colour.value;
      rgb.green = colour.value;
      rgb.blue  = colour.value;
    end else begin
      frac   = ((colour.hue % DegPerSector) * FracFull) / DegPerSector;
      sector = sector_t'(colour.hue / DegPerSector);
      p = (val * (Scale - sat)) / Scale;
      q = (val * (Scale - (sat * frac) / Scale)) / Scale;
      t = (val * (Scale - (sat * (Scale - frac)) / Scale)) / Scale;
      // Hues of 300 and above, including those past 359, take the last case.
      case (sector)
        SectorRedYellow: begin
          rgb.red = val[7:0]; rgb.green = t[7:0];   rgb.blue = p[7:0];
        end
        SectorYellowGreen: begin
          rgb.red = q[7:0];   rgb.green = val[7:0]; rgb.blue = p[7:0];
        end
        SectorGreenCyan: begin
          rgb.red = p[7:0];   rgb.green = val[7:0]; rgb.blue = t[7:0];
        end
        SectorCyanBlue: begin
          rgb.red = p[7:0];   rgb.green = q[7:0];   rgb.blue = val[7:0];
        end
        SectorBlueMagenta: begin
          rgb.red = t[7:0];   rgb.green = p[7:0];   rgb.blue = val[7:0];
        end
        default: begin
          rgb.red = val[7:0]; rgb.green = p[7:0];   rgb.blue = q[7:0];
        end
      endcase
    end
    return rgb;
  endfunction

  task automatic compare_channel(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Record each accepted colour, then check any result strobed this cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t expected;
    if (!rst_ni) begin
      expected_colours.delete();
      pending_count = 0;
    end else begin
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        expected_colours.insert(expected_colours.size(), predict_rgb(hsv_i));
      end
      if (done_i === 1'b1) begin
        if (expected_colours.size() == 0) begin
          $error("result transfer with no colour outstanding: got %0d/%0d/%0d",
                 rgb_i.red, rgb_i.green, rgb_i.blue);
          fail_count++;
        end else begin
          expected = expected_colours.pop_front();
          compare_channel("red", expected.red, rgb_i.red);
          compare_channel("green", expected.green, rgb_i.green);
          compare_channel("blue", expected.blue, rgb_i.blue);
          checked_count++;
        end
      end
      pending_count = expected_colours.size();
    end
  end

endmodule

// ===== tb/hsv_to_rgb_integer_test.sv =====
module hsv_to_rgb_integer_test;
  import h2r_pkg::*;

  localparam int ColoursPerPhase = 500;
  localparam int DrainCycles     = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  hsv_t in_i   = '0;
  logic done_o;
  rgb_t out_o;

  int error_count;
  int pending;
  int checked;
  int sent_count = 0;
  int grey_count = 0;
  int wrapped_count = 0;

  hsv_t directed[$];

  hsv_to_rgb_integer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  hsv_to_rgb_integer_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .hsv_i         (in_i),
    .done_i        (done_o),
    .rgb_i         (out_o),
    .error_count_o (error_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always #5 clk_i = ~clk_i;

  // Queue one directed colour behind those already listed.
  function automatic void add_directed(input hsv_t colour);
    directed.insert(directed.size(), colour);
  endfunction

  // Hold the start request up until the block takes the transfer.
  task automatic send_colour(input hsv_t colour);
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= colour;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sent_count++;
    if (colour.saturation == 0) grey_count++;
    if (colour.hue >= 9'd360) wrapped_count++;
  endtask

  task automatic idle_cycle();
    @(negedge clk_i);
    start <= 1'b0;
    in_i  <= hsv_t'($urandom);
  endtask

  // Mostly nominal hues, with a share past 359 and a share of greys.
  function automatic hsv_t random_colour();
    hsv_t colour;
    if ($urandom_range(0, 7) == 0) colour.hue = 9'($urandom_range(360, 511));
    else colour.hue = 9'($urandom_range(0, 359));
    if ($urandom_range(0, 7) == 0) colour.saturation = '0;
    else colour.saturation = 8'($urandom_range(0, 255));
    colour.value = 8'($urandom_range(0, 255));
    return colour;
  endfunction

  initial begin
    int   idle_pct[4];
    idle_pct = '{0, 75, 29, 0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Greys, including the extremes of value and a hue past 359.
    add_directed('{hue: 9'd100, saturation: 8'd0, value: 8'd200});
    add_directed('{hue: 9'd511, saturation: 8'd0, value: 8'd255});
    add_directed('{hue: 9'd0,   saturation: 8'd0, value: 8'd0});
    // Both edges of every sector, then the sectors beyond 359.
    add_directed('{hue: 9'd0,   saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd59,  saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd60,  saturation: 8'd1,   value: 8'd255});
    add_directed('{hue: 9'd119, saturation: 8'd128, value: 8'd200});
    add_directed('{hue: 9'd120, saturation: 8'd255, value: 8'd1});
    add_directed('{hue: 9'd179, saturation: 8'd200, value: 8'd255});
    add_directed('{hue: 9'd180, saturation: 8'd255, value: 8'd128});
    add_directed('{hue: 9'd239, saturation: 8'd1,   value: 8'd1});
    add_directed('{hue: 9'd240, saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd299, saturation: 8'd255, value: 8'd0});
    add_directed('{hue: 9'd300, saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd359, saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd360, saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd419, saturation: 8'd170, value: 8'd255});
    add_directed('{hue: 9'd420, saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd479, saturation: 8'd85,  value: 8'd99});
    add_directed('{hue: 9'd480, saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd511, saturation: 8'd255, value: 8'd255});
    add_directed('{hue: 9'd30,  saturation: 8'd1,   value: 8'd255});
    add_directed('{hue: 9'd90,  saturation: 8'd128, value: 8'd0});
    add_directed('{hue: 9'd150, saturation: 8'd255, value: 8'd1});
    foreach (directed[i]) send_colour(directed[i]);

    // Random colours under several sender idling rates.
    foreach (idle_pct[ph]) begin
      repeat (ColoursPerPhase) begin
        while ($urandom_range(0, 99) < idle_pct[ph]) idle_cycle();
        send_colour(random_colour());
      end
    end
    @(negedge clk_i);
    start <= 1'b0;

    // Let the pipeline drain, then keep watching for stray results.
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d colours (%0d grey, %0d with hue past 359), %0d results checked.",
             sent_count, grey_count, wrapped_count, checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung pipeline.
  initial begin
    #1000000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
